// ===== rtl/pfsr_pkg.sv =====
// Package for the polyline fixed-step resampler.
// Holds the transaction types, the datapath command and status types and the
// fixed widths and tables; it depends on nothing.
package pfsr_pkg;

   localparam int COORD_W      = 20;
   localparam int HEAD_W       = 16;
   localparam int STEP_W       = 12;
   localparam int DELTA_W      = 21;
   localparam int D2_W         = 42;
   localparam int RAD_W        = 58;
   localparam int ROOT_W       = 29;
   localparam int SQRT_ITERS   = 29;
   localparam int DIVD_W       = 42;
   localparam int DIVS_W       = 30;
   localparam int DIV_ITERS    = 42;
   localparam int CORDIC_ITERS = 16;
   localparam int CORDIC_W     = 34;
   localparam int ANGLE_W      = 20;
   localparam int ITER_W       = 6;

   localparam logic [STEP_W-1:0]  STEP_RESET = 12'd50;
   localparam logic [ANGLE_W-1:0] PI_Q16     = 20'd205887;

   typedef struct packed {
      logic signed [COORD_W-1:0] point_x;
      logic signed [COORD_W-1:0] point_y;
      logic signed [HEAD_W-1:0]  point_heading;
      logic                      final_point;
   } req_type;

   typedef struct packed {
      logic signed [COORD_W-1:0] out_x;
      logic signed [COORD_W-1:0] out_y;
      logic signed [HEAD_W-1:0]  out_heading;
      logic                      run_end;
      logic                      path_end;
      logic                      clipped;
   } rsp_type;

   typedef enum logic [4:0] {
      OP_IDLE,
      OP_LOAD,
      OP_SQX,
      OP_SQY,
      OP_COUNT,
      OP_SQRT_INIT,
      OP_SQRT,
      OP_DIVX_INIT,
      OP_DIVY_INIT,
      OP_DIV,
      OP_DIV_STORE_X,
      OP_DIV_STORE_Y,
      OP_CORDIC_INIT,
      OP_CORDIC,
      OP_EMIT_PREV,
      OP_EMIT_MID,
      OP_EMIT_FIN,
      OP_COMMIT
   } dp_op_type;

   typedef struct packed {
      dp_op_type op;
   } cmd_type;

   typedef struct packed {
      logic have_prev;
      logic final_point;
      logic count_done;
      logic n_ge2;
      logic mid_last;
      logic sqrt_last;
      logic div_last;
      logic cordic_last;
      logic out_free;
   } status_type;

   // Angle table, round(atan(2^-i) * 65536).
   function automatic logic [ANGLE_W-1:0] atan_entry(input logic [3:0] i);
      logic [ANGLE_W-1:0] v;
      case (i)
         4'd0:    v = 20'd51472;
         4'd1:    v = 20'd30386;
         4'd2:    v = 20'd16055;
         4'd3:    v = 20'd8150;
         4'd4:    v = 20'd4091;
         4'd5:    v = 20'd2047;
         4'd6:    v = 20'd1024;
         4'd7:    v = 20'd512;
         4'd8:    v = 20'd256;
         4'd9:    v = 20'd128;
         4'd10:   v = 20'd64;
         4'd11:   v = 20'd32;
         4'd12:   v = 20'd16;
         4'd13:   v = 20'd8;
         4'd14:   v = 20'd4;
         4'd15:   v = 20'd2;
         default: v = '0;
      endcase
      return v;
   endfunction

endpackage

// ===== rtl/pfsr_ctrl.sv =====
// Controller state machine of the polyline fixed-step resampler.
// Sequences the datapath phases through commands; uses pfsr_pkg.
module pfsr_ctrl (
   input  logic                clock,
   input  logic                reset,
   input  logic                req_valid,
   output logic                req_stall,
   input  pfsr_pkg::status_type status,
   output pfsr_pkg::cmd_type   cmd
);

   typedef enum logic [4:0] {
      S_IDLE, S_SQX, S_SQY, S_COUNT, S_SQRT_INIT, S_SQRT,
      S_DIVX_INIT, S_DIVX, S_DIVX_STORE, S_DIVY_INIT, S_DIVY, S_DIVY_STORE,
      S_CORDIC_INIT, S_CORDIC, S_EMIT_PREV, S_EMIT_MID, S_EMIT_FIN, S_DONE
   } state_type;

   state_type state_ff, state_in;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

   assign req_stall = (state_ff != S_IDLE);

   always_comb begin
      state_in = state_ff;
      cmd.op   = pfsr_pkg::OP_IDLE;
      case (state_ff)
         S_IDLE: begin
            if (req_valid) begin
               cmd.op = pfsr_pkg::OP_LOAD;
               if (status.have_prev) begin
                  state_in = S_SQX;
               end else if (status.final_point) begin
                  state_in = S_EMIT_FIN;
               end else begin
                  state_in = S_DONE;
               end
            end
         end
         S_SQX: begin
            cmd.op   = pfsr_pkg::OP_SQX;
            state_in = S_SQY;
         end
         S_SQY: begin
            cmd.op   = pfsr_pkg::OP_SQY;
            state_in = S_COUNT;
         end
         S_COUNT: begin
            cmd.op = pfsr_pkg::OP_COUNT;
            if (status.count_done) begin
               state_in = status.n_ge2 ? S_SQRT_INIT : S_EMIT_PREV;
            end
         end
         S_SQRT_INIT: begin
            cmd.op   = pfsr_pkg::OP_SQRT_INIT;
            state_in = S_SQRT;
         end
         S_SQRT: begin
            cmd.op = pfsr_pkg::OP_SQRT;
            if (status.sqrt_last) begin
               state_in = S_DIVX_INIT;
            end
         end
         S_DIVX_INIT: begin
            cmd.op   = pfsr_pkg::OP_DIVX_INIT;
            state_in = S_DIVX;
         end
         S_DIVX: begin
            cmd.op = pfsr_pkg::OP_DIV;
            if (status.div_last) begin
               state_in = S_DIVX_STORE;
            end
         end
         S_DIVX_STORE: begin
            cmd.op   = pfsr_pkg::OP_DIV_STORE_X;
            state_in = S_DIVY_INIT;
         end
         S_DIVY_INIT: begin
            cmd.op   = pfsr_pkg::OP_DIVY_INIT;
            state_in = S_DIVY;
         end
         S_DIVY: begin
            cmd.op = pfsr_pkg::OP_DIV;
            if (status.div_last) begin
               state_in = S_DIVY_STORE;
            end
         end
         S_DIVY_STORE: begin
            cmd.op   = pfsr_pkg::OP_DIV_STORE_Y;
            state_in = S_CORDIC_INIT;
         end
         S_CORDIC_INIT: begin
            cmd.op   = pfsr_pkg::OP_CORDIC_INIT;
            state_in = S_CORDIC;
         end
         S_CORDIC: begin
            cmd.op = pfsr_pkg::OP_CORDIC;
            if (status.cordic_last) begin
               state_in = S_EMIT_PREV;
            end
         end
         S_EMIT_PREV: begin
            cmd.op = pfsr_pkg::OP_EMIT_PREV;
            if (status.out_free) begin
               if (status.n_ge2) begin
                  state_in = S_EMIT_MID;
               end else if (status.final_point) begin
                  state_in = S_EMIT_FIN;
               end else begin
                  state_in = S_DONE;
               end
            end
         end
         S_EMIT_MID: begin
            cmd.op = pfsr_pkg::OP_EMIT_MID;
            if (status.out_free && status.mid_last) begin
               state_in = status.final_point ? S_EMIT_FIN : S_DONE;
            end
         end
         S_EMIT_FIN: begin
            cmd.op = pfsr_pkg::OP_EMIT_FIN;
            if (status.out_free) begin
               state_in = S_DONE;
            end
         end
         S_DONE: begin
            cmd.op   = pfsr_pkg::OP_COMMIT;
            state_in = S_IDLE;
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

endmodule

// ===== rtl/pfsr_datapath.sv =====
// Datapath of the polyline fixed-step resampler: segment arithmetic, the
// shared iteration counter, square root, divider, CORDIC, point walk and the
// output register. Uses pfsr_pkg.
module pfsr_datapath #(
   parameter int MAX_STEPS = 63
) (
   input  logic                 clock,
   input  logic                 reset,
   input  pfsr_pkg::req_type    req_data,
   input  logic                 csr_write_enable,
   input  logic [pfsr_pkg::STEP_W-1:0] csr_write_data,
   input  logic                 rsp_stall,
   output logic                 rsp_valid,
   output pfsr_pkg::rsp_type    rsp_data,
   input  pfsr_pkg::cmd_type    cmd,
   output pfsr_pkg::status_type status
);

   localparam int NW    = $clog2(MAX_STEPS + 1);
   localparam int SS_W  = 2 * pfsr_pkg::STEP_W;
   localparam int ACC_W = 2 * NW + SS_W + 2;
   localparam int CMP_W = (ACC_W > pfsr_pkg::D2_W ? ACC_W : pfsr_pkg::D2_W) + 1;
   localparam int K_W   = pfsr_pkg::DELTA_W + pfsr_pkg::STEP_W;
   localparam int CW    = pfsr_pkg::CORDIC_W;
   localparam int AW    = pfsr_pkg::ANGLE_W;

   // Configuration and path state.
   logic [pfsr_pkg::STEP_W-1:0]        step_ff;
   logic                               have_prev_ff;
   logic signed [pfsr_pkg::COORD_W-1:0] prev_x_ff, prev_y_ff;
   logic signed [pfsr_pkg::HEAD_W-1:0]  prev_h_ff;
   pfsr_pkg::req_type                  cur_ff;

   // Segment values.
   logic signed [pfsr_pkg::DELTA_W-1:0] dx_ff, dy_ff;
   logic [SS_W-1:0]                    ss_ff;
   logic [pfsr_pkg::D2_W-1:0]          sqx_ff, d2_ff;
   logic [K_W-1:0]                     kx_ff, ky_ff;
   logic [NW-1:0]                      n_ff;
   logic [ACC_W-1:0]                   acc_ff, inc_ff;
   logic                               clip_ff;
   logic [pfsr_pkg::ITER_W-1:0]        iter_ff;

   // Square root and divider.
   logic [pfsr_pkg::RAD_W-1:0]         rad_ff;
   logic [pfsr_pkg::ROOT_W:0]          srem_ff;
   logic [pfsr_pkg::ROOT_W-1:0]        root_ff;
   logic [pfsr_pkg::DIVD_W-1:0]        dvd_ff;
   logic [pfsr_pkg::DIVS_W-1:0]        drem_ff;
   logic [pfsr_pkg::COORD_W-1:0]       quo_ff;
   logic [pfsr_pkg::COORD_W-1:0]       qx0_ff, qy0_ff;
   logic [pfsr_pkg::DIVS_W-1:0]        rx0_ff, ry0_ff;

   // CORDIC and walk.
   logic signed [CW-1:0]               cx_ff, cy_ff;
   logic signed [AW-1:0]               cz_ff;
   logic [pfsr_pkg::COORD_W-1:0]       qx_ff, qy_ff;
   logic [pfsr_pkg::DIVS_W-1:0]        rx_ff, ry_ff;
   logic [NW-1:0]                      j_ff;

   logic                               rsp_valid_ff;
   pfsr_pkg::rsp_type                  rsp_data_ff;

   // Combinational helpers.
   logic [pfsr_pkg::STEP_W-1:0]        step_eff;
   logic signed [pfsr_pkg::DELTA_W-1:0] in_dx, in_dy;
   logic [pfsr_pkg::DELTA_W-1:0]       mag_x, mag_y;
   logic signed [pfsr_pkg::D2_W-1:0]   sq_x, sq_y;
   logic [ACC_W:0]                     trial_sum;
   logic                               fits, n_lt_max, count_done;
   logic [pfsr_pkg::ROOT_W+2:0]        sq_cur;
   logic [pfsr_pkg::ROOT_W+1:0]        sq_trial;
   logic [pfsr_pkg::DIVS_W:0]          dv_cur;
   logic [pfsr_pkg::DIVS_W-1:0]        divisor;
   logic signed [CW-1:0]               xs, ys, cx_init, cy_init;
   logic [3:0]                         shift;
   logic signed [AW-1:0]               z_round;
   logic [pfsr_pkg::DIVS_W:0]          sum_x, sum_y;
   logic                               carry_x, carry_y;
   logic [pfsr_pkg::DIVS_W-1:0]        next_rx, next_ry;
   logic [pfsr_pkg::COORD_W-1:0]       next_qx, next_qy, off_x, off_y;
   logic                               out_free;

   assign step_eff = (step_ff == '0) ? pfsr_pkg::STEP_W'(1) : step_ff;
   assign in_dx = pfsr_pkg::DELTA_W'(req_data.point_x) - pfsr_pkg::DELTA_W'(prev_x_ff);
   assign in_dy = pfsr_pkg::DELTA_W'(req_data.point_y) - pfsr_pkg::DELTA_W'(prev_y_ff);
   assign mag_x = dx_ff[pfsr_pkg::DELTA_W-1] ? pfsr_pkg::DELTA_W'(-dx_ff) : dx_ff;
   assign mag_y = dy_ff[pfsr_pkg::DELTA_W-1] ? pfsr_pkg::DELTA_W'(-dy_ff) : dy_ff;
   assign sq_x  = pfsr_pkg::D2_W'(dx_ff) * pfsr_pkg::D2_W'(dx_ff);
   assign sq_y  = pfsr_pkg::D2_W'(dy_ff) * pfsr_pkg::D2_W'(dy_ff);

   // The count loop keeps acc = n^2 * ss and inc = (2n + 1) * ss.
   assign trial_sum  = (ACC_W + 1)'(acc_ff) + (ACC_W + 1)'(inc_ff);
   assign fits       = CMP_W'(trial_sum) <= CMP_W'(d2_ff);
   assign n_lt_max   = n_ff < NW'(MAX_STEPS);
   assign count_done = !(n_lt_max && fits);

   assign sq_cur   = {srem_ff, rad_ff[pfsr_pkg::RAD_W-1 -: 2]};
   assign sq_trial = {root_ff, 2'b01};

   assign divisor = {root_ff, 1'b0};
   assign dv_cur  = {drem_ff, dvd_ff[pfsr_pkg::DIVD_W-1]};

   assign shift = iter_ff[3:0];
   assign xs    = cx_ff >>> shift;
   assign ys    = cy_ff >>> shift;
   assign cx_init = CW'(dx_ff) <<< 10;
   assign cy_init = CW'(dy_ff) <<< 10;
   assign z_round = cz_ff + AW'(4);

   // One step of the incremental rounded quotient for each coordinate.
   assign sum_x   = (pfsr_pkg::DIVS_W + 1)'(rx_ff) + (pfsr_pkg::DIVS_W + 1)'(rx0_ff);
   assign sum_y   = (pfsr_pkg::DIVS_W + 1)'(ry_ff) + (pfsr_pkg::DIVS_W + 1)'(ry0_ff);
   assign carry_x = sum_x >= (pfsr_pkg::DIVS_W + 1)'(divisor);
   assign carry_y = sum_y >= (pfsr_pkg::DIVS_W + 1)'(divisor);
   assign next_rx = pfsr_pkg::DIVS_W'(carry_x ? sum_x - (pfsr_pkg::DIVS_W + 1)'(divisor) : sum_x);
   assign next_ry = pfsr_pkg::DIVS_W'(carry_y ? sum_y - (pfsr_pkg::DIVS_W + 1)'(divisor) : sum_y);
   assign next_qx = qx_ff + qx0_ff + pfsr_pkg::COORD_W'(carry_x);
   assign next_qy = qy_ff + qy0_ff + pfsr_pkg::COORD_W'(carry_y);
   assign off_x   = dx_ff[pfsr_pkg::DELTA_W-1] ? -next_qx : next_qx;
   assign off_y   = dy_ff[pfsr_pkg::DELTA_W-1] ? -next_qy : next_qy;

   assign out_free = !rsp_valid_ff || !rsp_stall;

   assign status.have_prev   = have_prev_ff;
   assign status.final_point = (cmd.op == pfsr_pkg::OP_IDLE || cmd.op == pfsr_pkg::OP_LOAD)
                               ? req_data.final_point : cur_ff.final_point;
   assign status.count_done  = count_done;
   assign status.n_ge2       = n_ff >= NW'(2);
   assign status.mid_last    = j_ff == (n_ff - NW'(1));
   assign status.sqrt_last   = iter_ff == pfsr_pkg::ITER_W'(pfsr_pkg::SQRT_ITERS - 1);
   assign status.div_last    = iter_ff == pfsr_pkg::ITER_W'(pfsr_pkg::DIV_ITERS - 1);
   assign status.cordic_last = iter_ff == pfsr_pkg::ITER_W'(pfsr_pkg::CORDIC_ITERS - 1);
   assign status.out_free    = out_free;

   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_data_ff;

   // Control state.
   always_ff @(posedge clock) begin
      if (reset) begin
         step_ff      <= pfsr_pkg::STEP_RESET;
         have_prev_ff <= 1'b0;
         prev_x_ff    <= '0;
         prev_y_ff    <= '0;
         prev_h_ff    <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         if (csr_write_enable) begin
            step_ff <= csr_write_data;
         end
         if (cmd.op == pfsr_pkg::OP_COMMIT) begin
            prev_x_ff    <= cur_ff.point_x;
            prev_y_ff    <= cur_ff.point_y;
            prev_h_ff    <= cur_ff.point_heading;
            have_prev_ff <= !cur_ff.final_point;
         end
         if (out_free) begin
            rsp_valid_ff <= (cmd.op == pfsr_pkg::OP_EMIT_PREV) ||
                            (cmd.op == pfsr_pkg::OP_EMIT_MID) ||
                            (cmd.op == pfsr_pkg::OP_EMIT_FIN);
         end
      end
   end

   // Arithmetic registers.
   always_ff @(posedge clock) begin
      case (cmd.op)
         pfsr_pkg::OP_LOAD: begin
            cur_ff  <= req_data;
            dx_ff   <= in_dx;
            dy_ff   <= in_dy;
            ss_ff   <= step_eff * step_eff;
            n_ff    <= '0;
            clip_ff <= 1'b0;
         end
         pfsr_pkg::OP_SQX: begin
            sqx_ff <= pfsr_pkg::D2_W'($unsigned(sq_x));
            kx_ff  <= K_W'(mag_x) * K_W'(step_eff);
         end
         pfsr_pkg::OP_SQY: begin
            d2_ff  <= sqx_ff + pfsr_pkg::D2_W'($unsigned(sq_y));
            ky_ff  <= K_W'(mag_y) * K_W'(step_eff);
            acc_ff <= '0;
            inc_ff <= ACC_W'(ss_ff);
         end
         pfsr_pkg::OP_COUNT: begin
            if (!count_done) begin
               acc_ff <= ACC_W'(trial_sum);
               inc_ff <= inc_ff + ACC_W'({ss_ff, 1'b0});
               n_ff   <= n_ff + NW'(1);
            end else begin
               clip_ff <= fits;
            end
         end
         pfsr_pkg::OP_SQRT_INIT: begin
            rad_ff  <= {d2_ff, 16'b0};
            srem_ff <= '0;
            root_ff <= '0;
            iter_ff <= '0;
         end
         pfsr_pkg::OP_SQRT: begin
            if (sq_cur >= (pfsr_pkg::ROOT_W + 3)'(sq_trial)) begin
               srem_ff <= (pfsr_pkg::ROOT_W + 1)'(sq_cur - (pfsr_pkg::ROOT_W + 3)'(sq_trial));
               root_ff <= {root_ff[pfsr_pkg::ROOT_W-2:0], 1'b1};
            end else begin
               srem_ff <= (pfsr_pkg::ROOT_W + 1)'(sq_cur);
               root_ff <= {root_ff[pfsr_pkg::ROOT_W-2:0], 1'b0};
            end
            rad_ff  <= {rad_ff[pfsr_pkg::RAD_W-3:0], 2'b00};
            iter_ff <= iter_ff + pfsr_pkg::ITER_W'(1);
         end
         pfsr_pkg::OP_DIVX_INIT, pfsr_pkg::OP_DIVY_INIT: begin
            // Dividend is 2 * |d| * step * 256.
            dvd_ff  <= (cmd.op == pfsr_pkg::OP_DIVX_INIT) ? {kx_ff, 9'b0} : {ky_ff, 9'b0};
            drem_ff <= '0;
            quo_ff  <= '0;
            iter_ff <= '0;
         end
         pfsr_pkg::OP_DIV: begin
            if (dv_cur >= (pfsr_pkg::DIVS_W + 1)'(divisor)) begin
               drem_ff <= pfsr_pkg::DIVS_W'(dv_cur - (pfsr_pkg::DIVS_W + 1)'(divisor));
               quo_ff  <= {quo_ff[pfsr_pkg::COORD_W-2:0], 1'b1};
            end else begin
               drem_ff <= pfsr_pkg::DIVS_W'(dv_cur);
               quo_ff  <= {quo_ff[pfsr_pkg::COORD_W-2:0], 1'b0};
            end
            dvd_ff  <= {dvd_ff[pfsr_pkg::DIVD_W-2:0], 1'b0};
            iter_ff <= iter_ff + pfsr_pkg::ITER_W'(1);
         end
         pfsr_pkg::OP_DIV_STORE_X: begin
            qx0_ff <= quo_ff;
            rx0_ff <= drem_ff;
         end
         pfsr_pkg::OP_DIV_STORE_Y: begin
            qy0_ff <= quo_ff;
            ry0_ff <= drem_ff;
         end
         pfsr_pkg::OP_CORDIC_INIT: begin
            // Left half-plane vectors are mirrored and start from plus or minus pi.
            if (dx_ff[pfsr_pkg::DELTA_W-1]) begin
               cx_ff <= -cx_init;
               cy_ff <= -cy_init;
               cz_ff <= dy_ff[pfsr_pkg::DELTA_W-1] ? -pfsr_pkg::PI_Q16 : pfsr_pkg::PI_Q16;
            end else begin
               cx_ff <= cx_init;
               cy_ff <= cy_init;
               cz_ff <= '0;
            end
            iter_ff <= '0;
            // The walk starts at remainder dist, which gives rounding to nearest.
            qx_ff <= '0;
            qy_ff <= '0;
            rx_ff <= pfsr_pkg::DIVS_W'(root_ff);
            ry_ff <= pfsr_pkg::DIVS_W'(root_ff);
            j_ff  <= NW'(1);
         end
         pfsr_pkg::OP_CORDIC: begin
            if (cy_ff < 0) begin
               cx_ff <= cx_ff - ys;
               cy_ff <= cy_ff + xs;
               cz_ff <= cz_ff - pfsr_pkg::atan_entry(shift);
            end else begin
               cx_ff <= cx_ff + ys;
               cy_ff <= cy_ff - xs;
               cz_ff <= cz_ff + pfsr_pkg::atan_entry(shift);
            end
            iter_ff <= iter_ff + pfsr_pkg::ITER_W'(1);
         end
         pfsr_pkg::OP_EMIT_MID: begin
            if (out_free) begin
               qx_ff <= next_qx;
               qy_ff <= next_qy;
               rx_ff <= next_rx;
               ry_ff <= next_ry;
               j_ff  <= j_ff + NW'(1);
            end
         end
         default: begin
         end
      endcase
   end

   // Output register.
   always_ff @(posedge clock) begin
      if (out_free) begin
         case (cmd.op)
            pfsr_pkg::OP_EMIT_PREV: begin
               rsp_data_ff.out_x       <= prev_x_ff;
               rsp_data_ff.out_y       <= prev_y_ff;
               rsp_data_ff.out_heading <= prev_h_ff;
               rsp_data_ff.run_end     <= (n_ff < NW'(2)) && !cur_ff.final_point;
               rsp_data_ff.path_end    <= 1'b0;
               rsp_data_ff.clipped     <= clip_ff;
            end
            pfsr_pkg::OP_EMIT_MID: begin
               rsp_data_ff.out_x       <= prev_x_ff + $signed(off_x);
               rsp_data_ff.out_y       <= prev_y_ff + $signed(off_y);
               rsp_data_ff.out_heading <= z_round[pfsr_pkg::HEAD_W+2:3];
               rsp_data_ff.run_end     <= status.mid_last && !cur_ff.final_point;
               rsp_data_ff.path_end    <= 1'b0;
               rsp_data_ff.clipped     <= clip_ff;
            end
            pfsr_pkg::OP_EMIT_FIN: begin
               rsp_data_ff.out_x       <= cur_ff.point_x;
               rsp_data_ff.out_y       <= cur_ff.point_y;
               rsp_data_ff.out_heading <= cur_ff.point_heading;
               rsp_data_ff.run_end     <= 1'b1;
               rsp_data_ff.path_end    <= 1'b1;
               rsp_data_ff.clipped     <= clip_ff;
            end
            default: begin
            end
         endcase
      end
   end

endmodule

// ===== rtl/polyline_fixed_step_resampler.sv =====
// Top level of the polyline fixed-step resampler.
// Joins pfsr_ctrl and pfsr_datapath; uses pfsr_pkg.
//
// Waypoints enter on the req_ channel, one transaction per waypoint, and the
// resampled points leave on the rsp_ channel, one transaction per point. The
// first waypoint of a path is stored; each later one emits the previous
// waypoint and the inserted points of the segment, and a final waypoint is
// emitted itself with path_end set. run_end marks the last point of a waypoint.
// csr_write_enable with csr_write_data sets step_mm (50 after reset).
// One waypoint is processed at a time; req_stall stays high while it works.
// A segment first counts its points; when two or more points are inserted,
// it then runs the bit-serial square root, the two 42-step divisions and
// the CORDIC. It emits its points one at a time and then commits. A short
// segment skips the square root, the divisions and the CORDIC.
// The last point sits in an output register, so the next waypoint is taken
// while it waits. A stall on rsp_ holds that register and the emit sequence.
// Synchronous reset clears the path state and the output valid.
module polyline_fixed_step_resampler #(
   parameter int MAX_STEPS = 63
) (
   input  logic                         clock,
   input  logic                         reset,
   input  logic                         req_valid,
   output logic                         req_stall,
   input  pfsr_pkg::req_type            req_data,
   output logic                         rsp_valid,
   input  logic                         rsp_stall,
   output pfsr_pkg::rsp_type            rsp_data,
   input  logic                         csr_write_enable,
   input  logic [pfsr_pkg::STEP_W-1:0]  csr_write_data
);

   pfsr_pkg::cmd_type    cmd;
   pfsr_pkg::status_type status;

   pfsr_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_stall (req_stall),
      .status    (status),
      .cmd       (cmd)
   );

   pfsr_datapath #(
      .MAX_STEPS (MAX_STEPS)
   ) u_datapath (
      .clock            (clock),
      .reset            (reset),
      .req_data         (req_data),
      .csr_write_enable (csr_write_enable),
      .csr_write_data   (csr_write_data),
      .rsp_stall        (rsp_stall),
      .rsp_valid        (rsp_valid),
      .rsp_data         (rsp_data),
      .cmd              (cmd),
      .status           (status)
   );

endmodule

// ===== rtl/pfsr_checker.sv =====
// Port-level checker for the polyline fixed-step resampler, with its bind.
// Depends on pfsr_pkg and the top level's ports.
module pfsr_checker (
   input logic              clock,
   input logic              reset,
   input logic              req_valid,
   input logic              req_stall,
   input pfsr_pkg::rsp_type rsp_data,
   input logic              rsp_valid,
   input logic              rsp_stall
);

   // Reset leaves the block idle and the output empty.
   a_reset_idle: assert property (@(posedge clock)
      reset |=> !rsp_valid && !req_stall)
      else $error("block not idle after reset");

   // Work on one waypoint at a time: an accepted transaction stalls the next.
   a_accept_busy: assert property (@(posedge clock) disable iff (reset)
      (req_valid && !req_stall) |=> req_stall)
      else $error("input not stalled after a transaction");

   // The end of a path is always the last point of its waypoint.
   a_path_end: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && rsp_data.path_end) |-> rsp_data.run_end)
      else $error("path_end without run_end");

   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && rsp_stall) |=> (rsp_valid && $stable(rsp_data)))
      else $error("stalled result changed");

endmodule

bind polyline_fixed_step_resampler pfsr_checker u_pfsr_checker (
   .clock     (clock),
   .reset     (reset),
   .req_valid (req_valid),
   .req_stall (req_stall),
   .rsp_data  (rsp_data),
   .rsp_valid (rsp_valid),
   .rsp_stall (rsp_stall)
);

// ===== tb/sv/pfsr_checker.sv =====
// Scoreboard for the polyline fixed-step resampler: watches the waypoint and
// point channels, predicts the resampled points and compares them.
// Depends on pfsr_pkg.
module pfsr_scoreboard #(
   parameter int MAX_STEPS = 63
) (
   input  logic              clock,
   input  logic              reset,
   input  logic              req_valid,
   input  logic              req_stall,
   input  pfsr_pkg::req_type req_data,
   input  logic              rsp_valid,
   input  logic              rsp_stall,
   input  pfsr_pkg::rsp_type rsp_data,
   input  logic              csr_write_enable,
   input  logic [11:0]       csr_write_data,
   output int                fail_count,
   output int                pending_points
);
   timeunit 1ns;
   timeprecision 1ps;

   localparam longint PI_FIX = 205887;

   pfsr_pkg::rsp_type point_queue[$];
   logic [11:0] spacing;
   longint     last_x, last_y, last_h;
   bit         path_open;

   function automatic longint shift_down(longint v, int k);
      return v >>> k;
   endfunction

   function automatic longint root_of(longint unsigned v);
      longint unsigned res, bitv;
      res = 0;
      bitv = 64'd1 << 62;
      while (bitv > v) bitv >>= 2;
      while (bitv != 0) begin
         if (v >= res + bitv) begin
            v -= res + bitv;
            res = (res >> 1) + bitv;
         end else begin
            res >>= 1;
         end
         bitv >>= 2;
      end
      return longint'(res);
   endfunction

   function automatic longint segment_heading(longint dx, longint dy);
      longint x, y, z, xs, ys;
      longint angles[16] = '{51472, 30386, 16055, 8150, 4091, 2047, 1024, 512,
                             256, 128, 64, 32, 16, 8, 4, 2};
      x = dx * 1024;
      y = dy * 1024;
      z = 0;
      if (dx < 0) begin
         x = -x;
         y = -y;
         z = (dy >= 0) ? PI_FIX : -PI_FIX;
      end
      for (int i = 0; i < 16; i++) begin
         xs = shift_down(x, i);
         ys = shift_down(y, i);
         if (y < 0) begin
            x = x - ys;
            y = y + xs;
            z -= angles[i];
         end else begin
            x = x + ys;
            y = y - xs;
            z += angles[i];
         end
      end
      return shift_down(z + 4, 3);
   endfunction

   function automatic longint point_offset(longint d, longint j, longint step,
                                           longint seg_len);
      longint mag, q;
      mag = (d < 0) ? -d : d;
      q = (2 * mag * j * step * 256 + seg_len) / (2 * seg_len);
      return (d < 0) ? -q : q;
   endfunction

   task automatic push_point(longint x, longint y, longint h, bit pend, bit clip);
      pfsr_pkg::rsp_type p;
      p.out_x = x[19:0];
      p.out_y = y[19:0];
      p.out_heading = h[15:0];
      p.run_end = 1'b0;
      p.path_end = pend;
      p.clipped = clip;
      point_queue = {point_queue, p};
   endtask

   task automatic predict_waypoint(pfsr_pkg::req_type w);
      longint x, y, h, dx, dy, d2, ss, step, n, seg_len, yaw;
      bit clip;
      int start;
      x = w.point_x;
      y = w.point_y;
      h = w.point_heading;
      clip = 0;
      start = point_queue.size();
      if (path_open) begin
         step = (spacing == 0) ? 1 : spacing;
         dx = x - last_x;
         dy = y - last_y;
         d2 = dx * dx + dy * dy;
         ss = step * step;
         n = 0;
         while (n < MAX_STEPS && (n + 1) * (n + 1) * ss <= d2) n++;
         if (n == MAX_STEPS && (MAX_STEPS + 1) * (MAX_STEPS + 1) * ss <= d2) clip = 1;
         push_point(last_x, last_y, last_h, 0, clip);
         if (n >= 2) begin
            seg_len = root_of(d2 * 65536);
            yaw = segment_heading(dx, dy);
            for (longint j = 1; j < n; j++)
               push_point(last_x + point_offset(dx, j, step, seg_len),
                          last_y + point_offset(dy, j, step, seg_len), yaw, 0, clip);
         end
      end
      if (w.final_point) begin
         push_point(x, y, h, 1, clip);
         path_open = 0;
      end else begin
         path_open = 1;
      end
      last_x = x;
      last_y = y;
      last_h = h;
      if (point_queue.size() > start) point_queue[$].run_end = 1'b1;
   endtask

   always @(posedge clock) begin
      pfsr_pkg::rsp_type e;
      if (reset) begin
         spacing <= pfsr_pkg::STEP_RESET;
         path_open = 0;
         last_x = 0;
         last_y = 0;
         last_h = 0;
         point_queue.delete();
         fail_count <= 0;
      end else begin
         if (csr_write_enable) spacing <= csr_write_data;
         if (req_valid && !req_stall) predict_waypoint(req_data);
         if (rsp_valid && !rsp_stall) begin
            if (point_queue.size() == 0) begin
               $error("point transaction with nothing expected: %p", rsp_data);
               fail_count <= fail_count + 1;
            end else begin
               e = point_queue.pop_front();
               if (rsp_data !== e) begin
                  fail_count <= fail_count + 1;
                  if (rsp_data.out_x !== e.out_x)
                     $error("out_x expected %0d got %0d", e.out_x, rsp_data.out_x);
                  if (rsp_data.out_y !== e.out_y)
                     $error("out_y expected %0d got %0d", e.out_y, rsp_data.out_y);
                  if (rsp_data.out_heading !== e.out_heading)
                     $error("out_heading expected %0d got %0d",
                            e.out_heading, rsp_data.out_heading);
                  if (rsp_data.run_end !== e.run_end)
                     $error("run_end expected %0b got %0b", e.run_end, rsp_data.run_end);
                  if (rsp_data.path_end !== e.path_end)
                     $error("path_end expected %0b got %0b", e.path_end, rsp_data.path_end);
                  if (rsp_data.clipped !== e.clipped)
                     $error("clipped expected %0b got %0b", e.clipped, rsp_data.clipped);
               end
            end
         end
      end
      pending_points <= point_queue.size();
   end
endmodule

// ===== tb/sv/tb.sv =====
// Top of the polyline fixed-step resampler testbench: clock, reset, waypoint
// stimulus, step register writes and the verdict. Uses pfsr_pkg, pfsr_scoreboard
// and polyline_fixed_step_resampler.
module tb;
   timeunit 1ns;
   timeprecision 1ps;

   logic              clock;
   logic              reset;
   logic              req_valid;
   logic              req_stall;
   pfsr_pkg::req_type req_data;
   logic              rsp_valid;
   logic              rsp_stall;
   pfsr_pkg::rsp_type rsp_data;
   logic              csr_write_enable;
   logic [11:0]       csr_write_data;
   int                fail_count;
   int                pending_points;
   int                cycle_count;
   bit                stall_heavy;

   polyline_fixed_step_resampler i_dut (
      .clock(clock), .reset(reset),
      .req_valid(req_valid), .req_stall(req_stall), .req_data(req_data),
      .rsp_valid(rsp_valid), .rsp_stall(rsp_stall), .rsp_data(rsp_data),
      .csr_write_enable(csr_write_enable), .csr_write_data(csr_write_data)
   );

   pfsr_scoreboard i_checker (
      .clock(clock), .reset(reset),
      .req_valid(req_valid), .req_stall(req_stall), .req_data(req_data),
      .rsp_valid(rsp_valid), .rsp_stall(rsp_stall), .rsp_data(rsp_data),
      .csr_write_enable(csr_write_enable), .csr_write_data(csr_write_data),
      .fail_count(fail_count), .pending_points(pending_points)
   );

   initial begin
      clock = 0;
      forever #5 clock = ~clock;
   end

   // Receiver stall pattern: alternates between calm and heavy stretches.
   always @(negedge clock) begin
      if (reset) begin
         rsp_stall <= 0;
      end else begin
         if ($urandom_range(0, 199) == 0) stall_heavy = ~stall_heavy;
         rsp_stall <= stall_heavy ? ($urandom_range(0, 99) < 60) : 1'b0;
      end
   end

   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count > 3000000) begin
         $display("polyline_fixed_step_resampler test failed");
         $finish;
      end
   end

   // Called at a falling edge; req_stall there holds until the next rising edge.
   task automatic send_waypoint(int x, int y, int h, int fin);
      pfsr_pkg::req_type w;
      w.point_x = 20'(x);
      w.point_y = 20'(y);
      w.point_heading = 16'(h);
      w.final_point = (fin != 0);
      req_valid <= 1;
      req_data <= w;
      while (req_stall) @(negedge clock);
      @(negedge clock);
      if ($urandom_range(0, 2) == 0) begin
         req_valid <= 0;
         repeat ($urandom_range(1, 6)) @(negedge clock);
      end
   endtask

   task automatic set_spacing(logic [11:0] v);
      req_valid <= 0;
      while (pending_points != 0) @(negedge clock);
      repeat (300) @(negedge clock);
      csr_write_enable <= 1;
      csr_write_data <= v;
      @(negedge clock);
      csr_write_enable <= 0;
   endtask

   // A path of random length: mostly small steps between waypoints, so segments resample.
   task automatic send_path(int span);
      int len, x, y;
      len = $urandom_range(1, 6);
      x = $urandom;
      y = $urandom;
      for (int k = 0; k < len; k++) begin
         if ($urandom_range(0, 9) == 0) begin
            x = $urandom;
            y = $urandom;
         end else begin
            x = x + int'($urandom_range(0, 2 * span)) - span;
            y = y + int'($urandom_range(0, 2 * span)) - span;
         end
         send_waypoint(x, y, $urandom, int'(k == len - 1));
      end
   endtask

   initial begin
      logic [11:0] steps[6] = '{12'd0, 12'd1, 12'd4095, 12'd7, 12'd300, 12'd50};
      reset = 1;
      req_valid = 0;
      req_data = '0;
      csr_write_enable = 0;
      csr_write_data = 0;
      repeat (12) @(posedge clock);
      @(negedge clock);
      reset <= 0;

      // Directed: lone final, zero-length, short, extremes and every quadrant.
      send_waypoint(5, -5, 32767, 1);
      send_waypoint(0, 0, -32768, 0);
      send_waypoint(0, 0, 0, 0);
      send_waypoint(20, 10, 1, 0);
      send_waypoint(400, 10, 2, 0);
      send_waypoint(100, 300, 3, 0);
      send_waypoint(-200, 300, 4, 0);
      send_waypoint(-200, -100, 5, 0);
      send_waypoint(-500, -100, 6, 0);
      send_waypoint(-300, -500, 7, 0);
      send_waypoint(-524288, -524288, -1, 0);
      send_waypoint(524287, 524287, 32767, 0);
      send_waypoint(524287, -524288, -32768, 1);
      send_waypoint(1000, 1000, 9, 0);
      send_waypoint(1000, 1200, 9, 1);

      foreach (steps[s]) begin
         set_spacing(steps[s]);
         for (int p = 0; p < 25; p++)
            send_path((steps[s] == 0) ? 40 : int'(steps[s]) * 20 + 10);
      end

      req_valid <= 0;
      while (pending_points != 0) @(negedge clock);
      repeat (300) @(negedge clock);
      if (fail_count == 0)
         $display("polyline_fixed_step_resampler test passed");
      else
         $display("polyline_fixed_step_resampler test failed");
      $finish;
   end
endmodule

// ===== files.f =====
rtl/pfsr_pkg.sv
rtl/pfsr_ctrl.sv
rtl/pfsr_datapath.sv
rtl/polyline_fixed_step_resampler.sv
rtl/pfsr_checker.sv
tb/sv/pfsr_checker.sv
tb/sv/tb.sv
